### hdl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the byte-level I2C master engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned ReqW   = 3;
  localparam int unsigned LimitW = 16;

  localparam logic [ReqW-1:0] REQ_TICK  = 3'd0;
  localparam logic [ReqW-1:0] REQ_START = 3'd1;
  localparam logic [ReqW-1:0] REQ_STOP  = 3'd2;
  localparam logic [ReqW-1:0] REQ_WRITE = 3'd3;
  localparam logic [ReqW-1:0] REQ_READ  = 3'd4;

  localparam logic [LimitW-1:0] ACK_LIMIT_RST = 16'd1000;

  typedef struct packed {
    logic [ReqW-1:0] req_type;
    logic [7:0]      write_data;
    logic            send_ack;
    logic            sda_level;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_fail;
  } result_t;

endpackage

### hdl/i2c_master_byte_engine_core.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core
// Byte-level I2C master: start, stop, write byte, read byte, driven by tick
// beats that carry the sampled SDA level.
//
//   channel | dir | beat contents
//   s_*     | in  | tuser: req_type; tdata: write_data, send_ack, sda_level
//   m_*     | out | tdata: scl_level, sda_drive, busy_res, done_res,
//           |     |        rx_byte, ack_fail
//   cfg_*   | in  | ack_timeout_limit write
//
// One beat per cycle while the output is not stalled; a beat passes the input
// register, then the phase sequencer into the output register.
// rst is synchronous: bus released, limit back to 1000.
// A stalled output holds the input register; a new beat is taken whenever
// the output register is empty or being drained.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_core
  import i2cm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // write_data[7:0], send_ack, sda_level, zero pad
  input  logic [ReqW-1:0]   s_tuser,   // req_type
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // scl_level, sda_drive, busy_res, done_res,
                                       // rx_byte[7:0], ack_fail, zero pad
  input  logic              cfg_we,
  input  logic [LimitW-1:0] cfg_data
);

  logic              in_valid;
  item_t             in_item;
  logic              out_free, step;
  logic [LimitW-1:0] ack_limit;
  result_t           res;

  assign out_free = ~m_tvalid | m_tready;
  assign step     = in_valid & out_free;
  assign s_tready = ~in_valid | out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_limit <= ACK_LIMIT_RST;
    end else if (cfg_we) begin
      ack_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type   <= s_tuser;
      in_item.write_data <= s_tdata[7:0];
      in_item.send_ack   <= s_tdata[8];
      in_item.sda_level  <= s_tdata[9];
    end
  end

  i2cm_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (in_item),
    .ack_limit (ack_limit),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {3'b000, res.ack_fail, res.rx_byte, res.done_res, res.busy_res,
                  res.sda_drive, res.scl_level};
    end
  end

endmodule

### hdl/i2cm_fsm.sv
// ----------------------------------------------------------------------------
// i2cm_fsm
// Bus phase sequencer: applies one beat per step and gives the line levels
// and status that follow it.
// ----------------------------------------------------------------------------
module i2cm_fsm
  import i2cm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  item_t             item,
  input  logic [LimitW-1:0] ack_limit,
  output result_t           result
);

  typedef enum logic [3:0] {
    PH_IDLE_FREE,
    PH_IDLE_HELD,
    PH_START_A,
    PH_START_B,
    PH_STOP_A,
    PH_STOP_B,
    PH_WR_LOW,
    PH_WR_HIGH,
    PH_ACK_LOW,
    PH_ACK_WAIT,
    PH_RD_LOW,
    PH_RD_HIGH,
    PH_RA_LOW,
    PH_RA_HIGH
  } phase_t;

  phase_t            phase, phase_next;
  logic [3:0]        bit_cnt, bit_cnt_next, bit_cnt_inc;
  logic [7:0]        shreg, shreg_next;
  logic [LimitW-1:0] poll_cnt, poll_cnt_next;
  logic              ack_choice, ack_choice_next;
  logic              fail, fail_next;
  logic [7:0]        rx_hold, rx_hold_next;
  logic              idle, idle_next, done;
  logic              scl, sda;

  assign idle        = (phase == PH_IDLE_FREE) || (phase == PH_IDLE_HELD);
  assign bit_cnt_inc = bit_cnt + 4'd1;

  always_comb begin
    phase_next      = phase;
    bit_cnt_next    = bit_cnt;
    shreg_next      = shreg;
    poll_cnt_next   = poll_cnt;
    ack_choice_next = ack_choice;
    fail_next       = fail;
    rx_hold_next    = rx_hold;
    done            = 1'b0;
    if (item.req_type == REQ_TICK) begin
      unique case (phase)
        PH_START_A: phase_next = PH_START_B;
        PH_START_B: begin
          phase_next = PH_IDLE_HELD;
          done       = 1'b1;
        end
        PH_STOP_A:  phase_next = PH_STOP_B;
        PH_STOP_B: begin
          phase_next = PH_IDLE_FREE;
          done       = 1'b1;
        end
        PH_WR_LOW:  phase_next = PH_WR_HIGH;
        PH_WR_HIGH: begin
          shreg_next   = {shreg[6:0], 1'b0};
          bit_cnt_next = bit_cnt_inc;
          phase_next   = bit_cnt_inc[3] ? PH_ACK_LOW : PH_WR_LOW;
        end
        PH_ACK_LOW: begin
          poll_cnt_next = '0;
          phase_next    = PH_ACK_WAIT;
        end
        PH_ACK_WAIT: begin
          if (!item.sda_level) begin
            phase_next = PH_IDLE_HELD;
            done       = 1'b1;
          end else if (poll_cnt >= ack_limit) begin
            fail_next  = 1'b1;
            phase_next = PH_STOP_A;
          end else begin
            poll_cnt_next = poll_cnt + 1'b1;
          end
        end
        PH_RD_LOW:  phase_next = PH_RD_HIGH;
        PH_RD_HIGH: begin
          shreg_next   = {shreg[6:0], item.sda_level};
          bit_cnt_next = bit_cnt_inc;
          phase_next   = bit_cnt_inc[3] ? PH_RA_LOW : PH_RD_LOW;
        end
        PH_RA_LOW:  phase_next = PH_RA_HIGH;
        PH_RA_HIGH: begin
          rx_hold_next = shreg;
          phase_next   = PH_IDLE_HELD;
          done         = 1'b1;
        end
        default: ;
      endcase
    end else if (idle) begin
      priority case (item.req_type)
        REQ_START: phase_next = PH_START_A;
        REQ_STOP:  phase_next = PH_STOP_A;
        REQ_WRITE: begin
          shreg_next   = item.write_data;
          bit_cnt_next = '0;
          fail_next    = 1'b0;
          phase_next   = PH_WR_LOW;
        end
        REQ_READ: begin
          shreg_next      = '0;
          bit_cnt_next    = '0;
          ack_choice_next = item.send_ack;
          phase_next      = PH_RD_LOW;
        end
        default: ;
      endcase
    end
  end

  // line levels after this beat
  always_comb begin
    unique case (phase_next)
      PH_IDLE_FREE: begin scl = 1'b1; sda = 1'b1; end
      PH_IDLE_HELD: begin scl = 1'b0; sda = 1'b0; end
      PH_START_A:   begin scl = 1'b1; sda = 1'b1; end
      PH_START_B:   begin scl = 1'b1; sda = 1'b0; end
      PH_STOP_A:    begin scl = 1'b0; sda = 1'b0; end
      PH_STOP_B:    begin scl = 1'b1; sda = 1'b0; end
      PH_WR_LOW:    begin scl = 1'b0; sda = shreg_next[7]; end
      PH_WR_HIGH:   begin scl = 1'b1; sda = shreg_next[7]; end
      PH_ACK_LOW:   begin scl = 1'b0; sda = 1'b1; end
      PH_ACK_WAIT:  begin scl = 1'b1; sda = 1'b1; end
      PH_RD_LOW:    begin scl = 1'b0; sda = 1'b1; end
      PH_RD_HIGH:   begin scl = 1'b1; sda = 1'b1; end
      PH_RA_LOW:    begin scl = 1'b0; sda = ~ack_choice_next; end
      PH_RA_HIGH:   begin scl = 1'b1; sda = ~ack_choice_next; end
      default:      begin scl = 1'b1; sda = 1'b1; end
    endcase
  end

  assign idle_next = (phase_next == PH_IDLE_FREE) || (phase_next == PH_IDLE_HELD);

  always_comb begin
    result.scl_level = scl;
    result.sda_drive = sda;
    result.busy_res  = ~idle_next;
    result.done_res  = done;
    result.rx_byte   = rx_hold_next;
    result.ack_fail  = fail_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE_FREE;
      bit_cnt    <= '0;
      shreg      <= '0;
      poll_cnt   <= '0;
      ack_choice <= 1'b0;
      fail       <= 1'b0;
      rx_hold    <= '0;
    end else if (step) begin
      phase      <= phase_next;
      bit_cnt    <= bit_cnt_next;
      shreg      <= shreg_next;
      poll_cnt   <= poll_cnt_next;
      ack_choice <= ack_choice_next;
      fail       <= fail_next;
      rx_hold    <= rx_hold_next;
    end
  end

endmodule
